[src/mrem_pkg.sv]
// ----------------------------------------------------------------------------
// mrem_pkg: shared types and constants
// Character codes, state codes and the per-request result bundle for the
// recipe expansion masker.
// ----------------------------------------------------------------------------
package mrem_pkg;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_PLAIN  = 2'd1,
    KIND_RECIPE = 2'd2
  } line_kind_t;

  typedef enum logic [1:0] {
    EXP_NONE  = 2'd0,
    EXP_PAREN = 2'd1,
    EXP_BRACE = 2'd2
  } exp_kind_t;

  // Results produced by one input request: count (0 to 2) and the bytes.
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } step_res_t;

endpackage

[src/mrem_step.sv]
// ----------------------------------------------------------------------------
// mrem_step: line and expansion tracker
// Holds the scan state and works out, for the byte on offer, the masked
// result bytes and the state after it.
// ----------------------------------------------------------------------------
module mrem_step #(
  parameter int NEST_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                end_of_source,
  output mrem_pkg::step_res_t res
);

  mrem_pkg::line_kind_t line_kind, line_kind_next;
  mrem_pkg::exp_kind_t  exp_kind, exp_kind_next;
  logic                 dollar_waiting, dollar_waiting_next;
  logic                 inner_dollar, inner_dollar_next;
  logic [NEST_BITS-1:0] nest, nest_next;

  always_comb begin
    logic [7:0]           opener;
    logic [7:0]           closer;
    logic                 clear;
    logic [NEST_BITS-1:0] nest_dec;
    line_kind_next      = line_kind;
    exp_kind_next       = exp_kind;
    dollar_waiting_next = dollar_waiting;
    inner_dollar_next   = inner_dollar;
    nest_next           = nest;
    res                 = '0;
    clear               = 1'b0;
    opener   = (exp_kind == mrem_pkg::EXP_PAREN) ? mrem_pkg::CH_LPAREN : mrem_pkg::CH_LBRACE;
    closer   = (exp_kind == mrem_pkg::EXP_PAREN) ? mrem_pkg::CH_RPAREN : mrem_pkg::CH_RBRACE;
    nest_dec = (nest != '0) ? nest - NEST_BITS'(1) : nest;

    case (line_kind)
      mrem_pkg::KIND_PLAIN: begin
        res.count = 2'd1;
        res.byte0 = data_byte;
        clear     = (data_byte == mrem_pkg::CH_LF);
      end
      mrem_pkg::KIND_RECIPE: begin
        if (exp_kind != mrem_pkg::EXP_NONE) begin
          res.count = 2'd1;
          if (data_byte == mrem_pkg::CH_LF) begin
            res.byte0 = data_byte;
            clear     = 1'b1;
          end else begin
            res.byte0 = mrem_pkg::CH_SPACE;
            if (inner_dollar && data_byte == opener) begin
              // saturate the nesting depth
              if (!(&nest)) nest_next = nest + NEST_BITS'(1);
              inner_dollar_next = 1'b0;
            end else begin
              inner_dollar_next = (data_byte == mrem_pkg::CH_DOLLAR);
              if (data_byte == closer) begin
                nest_next = nest_dec;
                if (nest_dec == '0) begin
                  exp_kind_next     = mrem_pkg::EXP_NONE;
                  inner_dollar_next = 1'b0;
                end
              end
            end
          end
        end else if (dollar_waiting) begin
          dollar_waiting_next = 1'b0;
          res.count = 2'd2;
          if (data_byte == mrem_pkg::CH_DOLLAR) begin
            res.byte0 = mrem_pkg::CH_SPACE;
            res.byte1 = mrem_pkg::CH_DOLLAR;
          end else if (data_byte == mrem_pkg::CH_LF) begin
            res.byte0 = mrem_pkg::CH_DOLLAR;
            res.byte1 = mrem_pkg::CH_LF;
            clear     = 1'b1;
          end else begin
            res.byte0 = mrem_pkg::CH_SPACE;
            res.byte1 = mrem_pkg::CH_SPACE;
            if (data_byte == mrem_pkg::CH_LPAREN || data_byte == mrem_pkg::CH_LBRACE) begin
              exp_kind_next = (data_byte == mrem_pkg::CH_LPAREN) ? mrem_pkg::EXP_PAREN
                                                                 : mrem_pkg::EXP_BRACE;
              nest_next         = NEST_BITS'(1);
              inner_dollar_next = 1'b0;
            end
          end
        end else if (data_byte == mrem_pkg::CH_DOLLAR) begin
          // hold the dollar until the next byte decides
          dollar_waiting_next = 1'b1;
        end else begin
          res.count = 2'd1;
          res.byte0 = data_byte;
          clear     = (data_byte == mrem_pkg::CH_LF);
        end
      end
      default: begin
        res.count = 2'd1;
        res.byte0 = data_byte;
        if (data_byte == mrem_pkg::CH_TAB)     line_kind_next = mrem_pkg::KIND_RECIPE;
        else if (data_byte != mrem_pkg::CH_LF) line_kind_next = mrem_pkg::KIND_PLAIN;
        else                                   line_kind_next = mrem_pkg::KIND_START;
      end
    endcase

    if (end_of_source) begin
      // flush a held dollar; nothing else was produced in that case
      if (dollar_waiting_next) begin
        res.count = 2'd1;
        res.byte0 = mrem_pkg::CH_DOLLAR;
      end
      clear = 1'b1;
    end

    if (clear) begin
      line_kind_next      = mrem_pkg::KIND_START;
      exp_kind_next       = mrem_pkg::EXP_NONE;
      dollar_waiting_next = 1'b0;
      inner_dollar_next   = 1'b0;
      nest_next           = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_kind      <= mrem_pkg::KIND_START;
      exp_kind       <= mrem_pkg::EXP_NONE;
      dollar_waiting <= 1'b0;
      inner_dollar   <= 1'b0;
      nest           <= '0;
    end else if (accept) begin
      line_kind      <= line_kind_next;
      exp_kind       <= exp_kind_next;
      dollar_waiting <= dollar_waiting_next;
      inner_dollar   <= inner_dollar_next;
      nest           <= nest_next;
    end
  end

  // an open expansion always has a nonzero depth
  a_nest_open: assert property (@(posedge clk) disable iff (rst)
    (exp_kind != mrem_pkg::EXP_NONE) |-> (nest != '0))
    else $error("open expansion with zero depth");

  // a held dollar only lives in a recipe line outside an expansion
  a_dollar_ctx: assert property (@(posedge clk) disable iff (rst)
    dollar_waiting |-> (line_kind == mrem_pkg::KIND_RECIPE && exp_kind == mrem_pkg::EXP_NONE))
    else $error("dollar held outside recipe text");

endmodule

[src/mrem_outq.sv]
// ----------------------------------------------------------------------------
// mrem_outq: result register pair
// Holds up to two result bytes of one request and drives them out in order,
// taking the next request when empty or as the last pending byte leaves.
// ----------------------------------------------------------------------------
module mrem_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrem_pkg::step_res_t res,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  logic [1:0] count;
  logic [7:0] slot0, slot1;
  logic       last0, last1;
  logic       pop, push;

  assign out_valid = (count != 2'd0);
  assign out_byte  = slot0;
  assign out_last  = last0;
  assign pop       = out_valid && out_ready;
  assign in_ready  = (count == 2'd0) || (count == 2'd1 && out_ready);
  assign push      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push) begin
      count <= res.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= res.byte0;
      last0 <= (res.count == 2'd1);
      slot1 <= res.byte1;
      last1 <= 1'b1;
    end else if (pop) begin
      slot0 <= slot1;
      last0 <= last1;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result count overflow");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> out_last)
    else $error("sole pending result not marked last");

  a_pair_first: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !out_last)
    else $error("first of two results marked last");

  a_pop_pair: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && out_ready) |=> (count == 2'd1 && out_valid))
    else $error("second result lost");

endmodule

[src/make_recipe_expansion_masker.sv]
// ----------------------------------------------------------------------------
// make_recipe_expansion_masker: recipe expansion masker
// Masks dollar sequences and expansions in tab-led recipe lines of makefile
// source, one byte per request.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while the result register pair can take
// its results. A byte gives zero, one or two result bytes; a request that
// gives two holds the input side while the second byte leaves the result
// register pair, and a new request is taken as the last pending byte leaves.
// A held dollar gives no result until the following byte (or the end of
// source) decides it. Results leave from the result register pair.
module make_recipe_expansion_masker #(
  parameter int NEST_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_source
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // last_of_run
);

  mrem_pkg::step_res_t res;
  logic                accept;

  assign accept = s_tvalid && s_tready;

  mrem_step #(
    .NEST_BITS(NEST_BITS)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_tdata),
    .end_of_source(s_tlast),
    .res          (res)
  );

  mrem_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .res      (res),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_byte (m_tdata),
    .out_last (m_tlast)
  );

endmodule

[dv/mrem_mask_checker.sv]
// ----------------------------------------------------------------------------
// mrem_mask_checker: result predictor and comparator
// Watches both stream channels of the recipe expansion masker. Every accepted
// source byte updates a local copy of the masking state and queues the result
// bytes it should cause. Every accepted result byte is checked against the
// oldest queued one.
// ----------------------------------------------------------------------------
module mrem_mask_checker #(
  parameter int NEST_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_source
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] out_byte
  input  logic       m_tlast,   // last_of_run
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } mask_res_t;

  mask_res_t masked_q[$];
  mask_res_t want;

  mrem_pkg::line_kind_t kind_r;
  logic                 held_r;
  mrem_pkg::exp_kind_t  exp_r;
  logic [NEST_BITS-1:0] depth_r;
  logic                 inner_r;

  task automatic clear_state();
    kind_r  = mrem_pkg::KIND_START;
    held_r  = 1'b0;
    exp_r   = mrem_pkg::EXP_NONE;
    depth_r = '0;
    inner_r = 1'b0;
  endtask

  task automatic mask_predict(input logic [7:0] b, input logic eos);
    logic [7:0] res [2];
    logic [7:0] opener;
    logic [7:0] closer;
    int         n;
    n = 0;
    case (kind_r)
      mrem_pkg::KIND_PLAIN: begin
        res[n] = b; n++;
        if (b == mrem_pkg::CH_LF) clear_state();
      end
      mrem_pkg::KIND_RECIPE: begin
        if (exp_r != mrem_pkg::EXP_NONE) begin
          if (b == mrem_pkg::CH_LF) begin
            res[n] = b; n++;
            clear_state();
          end else begin
            opener = (exp_r == mrem_pkg::EXP_PAREN) ? mrem_pkg::CH_LPAREN : mrem_pkg::CH_LBRACE;
            closer = (exp_r == mrem_pkg::EXP_PAREN) ? mrem_pkg::CH_RPAREN : mrem_pkg::CH_RBRACE;
            res[n] = mrem_pkg::CH_SPACE; n++;
            if (inner_r && b == opener) begin
              // saturate the nesting depth
              if (depth_r != '1) depth_r++;
              inner_r = 1'b0;
            end else begin
              inner_r = (b == mrem_pkg::CH_DOLLAR);
              if (b == closer) begin
                if (depth_r != '0) depth_r--;
                if (depth_r == '0) begin
                  exp_r   = mrem_pkg::EXP_NONE;
                  inner_r = 1'b0;
                end
              end
            end
          end
        end else if (held_r) begin
          held_r = 1'b0;
          if (b == mrem_pkg::CH_DOLLAR) begin
            res[0] = mrem_pkg::CH_SPACE; res[1] = mrem_pkg::CH_DOLLAR; n = 2;
          end else if (b == mrem_pkg::CH_LF) begin
            res[0] = mrem_pkg::CH_DOLLAR; res[1] = mrem_pkg::CH_LF; n = 2;
            clear_state();
          end else begin
            res[0] = mrem_pkg::CH_SPACE; res[1] = mrem_pkg::CH_SPACE; n = 2;
            if (b == mrem_pkg::CH_LPAREN || b == mrem_pkg::CH_LBRACE) begin
              exp_r   = (b == mrem_pkg::CH_LPAREN) ? mrem_pkg::EXP_PAREN : mrem_pkg::EXP_BRACE;
              depth_r = NEST_BITS'(1);
              inner_r = 1'b0;
            end
          end
        end else if (b == mrem_pkg::CH_DOLLAR) begin
          held_r = 1'b1;
        end else begin
          res[n] = b; n++;
          if (b == mrem_pkg::CH_LF) clear_state();
        end
      end
      default: begin
        res[n] = b; n++;
        if (b == mrem_pkg::CH_TAB) kind_r = mrem_pkg::KIND_RECIPE;
        else if (b != mrem_pkg::CH_LF) kind_r = mrem_pkg::KIND_PLAIN;
        else kind_r = mrem_pkg::KIND_START;
      end
    endcase
    if (eos) begin
      // release a dollar still held at the end of source
      if (held_r) begin
        res[n] = mrem_pkg::CH_DOLLAR; n++;
      end
      clear_state();
    end
    for (int i = 0; i < n; i++) masked_q.push_back('{data: res[i], last: (i == n - 1)});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      masked_q.delete();
      errors = 0;
    end else begin
      // compare first so a result never matches a byte accepted at this edge
      if (m_tvalid && m_tready) begin
        if (masked_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %02h last %0b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = masked_q.pop_front();
          if (m_tdata !== want.data || m_tlast !== want.last) begin
            errors++;
            $display("%0t: result mismatch, expected %02h last %0b, got %02h last %0b",
                     $time, want.data, want.last, m_tdata, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready) mask_predict(s_tdata, s_tlast);
    end
    pending = masked_q.size();
  end

endmodule

[dv/make_recipe_expansion_masker_tb.sv]
// ----------------------------------------------------------------------------
// make_recipe_expansion_masker_tb: stream test of the expansion masker
// Feeds makefile-like source: a few directed lines for dollar pairs, held
// dollars, nesting, inner dollars and end of source, then random plain and
// recipe lines with well-formed and broken expansions and one deep nest that
// can saturate. Both channels idle at random; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module make_recipe_expansion_masker_tb;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  int         errors;
  int         pending;

  int         items;
  bit         calm;
  bit         deep_run;
  bit         deep_done;

  logic [7:0] specials [8] = '{mrem_pkg::CH_DOLLAR, mrem_pkg::CH_LPAREN,
                               mrem_pkg::CH_RPAREN, mrem_pkg::CH_LBRACE,
                               mrem_pkg::CH_RBRACE, mrem_pkg::CH_TAB,
                               mrem_pkg::CH_SPACE, mrem_pkg::CH_LF};

  make_recipe_expansion_masker u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  mrem_mask_checker u_chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_src(input logic [7:0] b, input logic eos);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items++;
  endtask

  // send a byte with a rare end of source, except inside the deep nest
  task automatic emit(input logic [7:0] b);
    push_src(b, !deep_run && ($urandom_range(0, 149) == 0));
  endtask

  task automatic send_text(input string s, input bit eos_last);
    for (int i = 0; i < s.len(); i++)
      push_src(s[i], eos_last && (i == s.len() - 1));
  endtask

  // result side stalls
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm || $urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
    end
  end

  initial begin
    #4000000;
    $display("make_recipe_expansion_masker test failed");
    $finish;
  end

  initial begin
    logic [7:0] op;
    logic [7:0] cl;
    logic [7:0] b;
    int         depth;
    int         blen;
    int         ntok;
    int         nd;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    items     = 0;
    calm      = 1'b0;
    deep_run  = 1'b0;
    deep_done = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // plain line with extreme bytes
    push_src(8'h00, 1'b0);
    push_src(8'hFF, 1'b0);
    push_src(mrem_pkg::CH_LF, 1'b0);
    // dollar pair, dollar before other byte, dollar before line feed
    send_text("\t$$$~$\n", 1'b0);
    // nested opener, inner dollar before closer, line feed inside expansion
    send_text("\t$($($)a\n", 1'b0);
    // inner dollar then closer ends the expansion, extra closer copied
    send_text("\t${$}}\n", 1'b0);
    // dollar held at end of source
    send_text("\t$", 1'b1);

    while (items < 1500) begin
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      if (!deep_done && items > 700) begin
        // push the nesting depth near or into saturation, then unwind it
        deep_done = 1'b1;
        deep_run  = 1'b1;
        emit(mrem_pkg::CH_TAB);
        nd = $urandom_range(250, 300);
        repeat (nd) begin
          emit(mrem_pkg::CH_DOLLAR);
          emit(mrem_pkg::CH_LPAREN);
        end
        repeat ($urandom_range(253, 262)) emit(mrem_pkg::CH_RPAREN);
        emit(mrem_pkg::CH_LF);
        deep_run = 1'b0;
      end
      case ($urandom_range(0, 19))
        0: emit(mrem_pkg::CH_LF);
        1, 2, 3, 4: begin
          b = 8'($urandom_range(0, 255));
          if (b == mrem_pkg::CH_TAB || b == mrem_pkg::CH_LF) b = 8'h70;
          emit(b);
          repeat ($urandom_range(0, 12)) begin
            if ($urandom_range(0, 1)) emit(8'($urandom_range(0, 255)));
            else emit(specials[$urandom_range(0, 7)]);
          end
          emit(mrem_pkg::CH_LF);
        end
        default: begin
          emit(mrem_pkg::CH_TAB);
          ntok = $urandom_range(1, 8);
          repeat (ntok) begin
            case ($urandom_range(0, 9))
              0: begin
                emit(mrem_pkg::CH_DOLLAR);
                emit(mrem_pkg::CH_DOLLAR);
              end
              1: begin
                emit(mrem_pkg::CH_DOLLAR);
                emit(8'(8'h61 + $urandom_range(0, 25)));
              end
              2, 3: begin
                op = $urandom_range(0, 1) ? mrem_pkg::CH_LPAREN : mrem_pkg::CH_LBRACE;
                cl = (op == mrem_pkg::CH_LPAREN) ? mrem_pkg::CH_RPAREN : mrem_pkg::CH_RBRACE;
                emit(mrem_pkg::CH_DOLLAR);
                emit(op);
                depth = 1;
                blen  = $urandom_range(0, 8);
                for (int k = 0; k < blen && depth > 0; k++) begin
                  case ($urandom_range(0, 7))
                    0: begin
                      emit(mrem_pkg::CH_DOLLAR);
                      emit(op);
                      depth++;
                    end
                    1: begin
                      emit(mrem_pkg::CH_DOLLAR);
                      emit(cl);
                      depth--;
                    end
                    2: begin
                      emit(mrem_pkg::CH_DOLLAR);
                      emit(8'(8'h61 + $urandom_range(0, 25)));
                    end
                    3: begin
                      emit(cl);
                      depth--;
                    end
                    4: emit(specials[$urandom_range(1, 4)]);
                    default: emit(8'(8'h61 + $urandom_range(0, 25)));
                  endcase
                end
                // leave some expansions open until the line feed
                if ($urandom_range(0, 5) != 0) repeat (depth) emit(cl);
              end
              4: emit(8'($urandom_range(0, 255)));
              5: emit(specials[$urandom_range(0, 7)]);
              default: emit(8'(8'h61 + $urandom_range(0, 25)));
            endcase
          end
          if ($urandom_range(0, 9) != 0) emit(mrem_pkg::CH_LF);
        end
      endcase
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("make_recipe_expansion_masker test passed");
    end else begin
      $display("make_recipe_expansion_masker test failed");
    end
    $finish;
  end

endmodule

[files.f]
src/mrem_pkg.sv
src/mrem_step.sv
src/mrem_outq.sv
src/make_recipe_expansion_masker.sv
dv/mrem_mask_checker.sv
dv/make_recipe_expansion_masker_tb.sv
